// ===== sv/jbt_pkg.sv =====
package jbt_pkg;

  localparam int unsigned POS_W = 16;

  // Token kinds
  localparam logic [3:0] KIND_NONE     = 4'd0;
  localparam logic [3:0] KIND_IDENT    = 4'd1;
  localparam logic [3:0] KIND_INT      = 4'd2;
  localparam logic [3:0] KIND_REAL     = 4'd3;
  localparam logic [3:0] KIND_LBRACE   = 4'd4;
  localparam logic [3:0] KIND_RBRACE   = 4'd5;
  localparam logic [3:0] KIND_LBRACKET = 4'd6;
  localparam logic [3:0] KIND_RBRACKET = 4'd7;
  localparam logic [3:0] KIND_QUOTE    = 4'd8;
  localparam logic [3:0] KIND_COMMA    = 4'd9;
  localparam logic [3:0] KIND_COLON    = 4'd10;

  // Error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_UNTERM    = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd2;

  // Characters
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;

  typedef struct packed {
    logic [3:0]       token_kind;
    logic [POS_W-1:0] token_offset;
    logic [POS_W-1:0] token_length;
    logic [1:0]       error_code;
    logic             run_end;
  } jbt_result_t;

  // Results produced by one byte, in delivery order
  typedef struct packed {
    logic [1:0]  count;
    jbt_result_t first;
    jbt_result_t second;
  } jbt_push_t;

endpackage

// ===== sv/jbt_channels.sv =====
interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface jbt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_offset;
  logic [15:0] token_length;
  logic [1:0]  error_code;
  logic        run_end;

  modport source (output valid, output token_kind, output token_offset,
                  output token_length, output error_code, output run_end,
                  input ready);
  modport sink   (input valid, input token_kind, input token_offset,
                  input token_length, input error_code, input run_end,
                  output ready);
endinterface

// ===== sv/jbt_lexer_core.sv =====
module jbt_lexer_core
  import jbt_pkg::*;
#(
  parameter int unsigned MAX_DOC_BYTES = 65536
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_data,
  input  logic      in_final,
  input  logic      space_ok,
  output jbt_push_t push
);

  localparam int unsigned POS_LIMIT = (MAX_DOC_BYTES > 65536) ? 65536 : MAX_DOC_BYTES;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(POS_LIMIT - 1);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_IDENT = 2'd1;
  localparam logic [1:0] MODE_INT   = 2'd2;
  localparam logic [1:0] MODE_REAL  = 2'd3;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
           (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_LBRACE:   k = KIND_LBRACE;
      CH_RBRACE:   k = KIND_RBRACE;
      CH_LBRACKET: k = KIND_LBRACKET;
      CH_RBRACKET: k = KIND_RBRACKET;
      CH_QUOTE:    k = KIND_QUOTE;
      CH_COMMA:    k = KIND_COMMA;
      CH_COLON:    k = KIND_COLON;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

  logic             vld_r;
  logic [7:0]       byte_r;
  logic             fin_r;
  logic [1:0]       mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic             ovf_r, ovf_nxt;
  logic             advance;

  logic             close, reidle, starts;
  logic [3:0]       close_kind, pk;
  logic [1:0]       mode_mid;
  logic [POS_W-1:0] start_mid;
  logic [POS_W-1:0] span;
  logic [POS_W:0]   full_wide;
  logic [POS_W-1:0] full;
  logic             has_a, has_b, has_c;
  jbt_result_t      res_a, res_b, res_c;
  logic [1:0]       err_base;

  assign advance  = vld_r && space_ok;
  assign in_ready = !vld_r || space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (advance) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data;
      fin_r  <= in_final;
    end
  end

  always_comb begin
    pk = punct_kind(byte_r);
    close      = 1'b0;
    close_kind = KIND_NONE;
    case (mode_r)
      MODE_IDENT: begin
        close      = (byte_r == CH_COMMA) || (byte_r == CH_QUOTE);
        close_kind = KIND_IDENT;
      end
      MODE_INT: begin
        close      = (byte_r != CH_DOT) && !is_digit(byte_r);
        close_kind = KIND_INT;
      end
      MODE_REAL: begin
        close      = !is_digit(byte_r);
        close_kind = KIND_REAL;
      end
      default: begin
        close      = 1'b0;
        close_kind = KIND_NONE;
      end
    endcase

    // Idle handling applies to a byte seen in idle or to the byte that closed a token
    reidle = (mode_r == MODE_IDLE) || close;
    starts = reidle && !is_space(byte_r) && (pk == KIND_NONE);

    mode_mid = mode_r;
    if (reidle) begin
      if (!starts) begin
        mode_mid = MODE_IDLE;
      end else if (is_digit(byte_r) || (byte_r == CH_MINUS)) begin
        mode_mid = MODE_INT;
      end else begin
        mode_mid = MODE_IDENT;
      end
    end else if ((mode_r == MODE_INT) && (byte_r == CH_DOT)) begin
      mode_mid = MODE_REAL;
    end
    start_mid = starts ? pos_r : start_r;

    span = (start_r > pos_r) ? '0 : pos_r - start_r;
    full_wide = (start_mid > pos_r) ? (POS_W+1)'(1)
              : {1'b0, pos_r} - {1'b0, start_mid} + (POS_W+1)'(1);
    full = full_wide[POS_W] ? '1 : full_wide[POS_W-1:0];

    err_base = ovf_r ? ERR_TOO_LONG : ERR_OK;

    has_a = close;
    res_a = '{token_kind: close_kind, token_offset: start_r, token_length: span,
              error_code: err_base, run_end: 1'b0};
    has_b = reidle && (pk != KIND_NONE);
    res_b = '{token_kind: pk, token_offset: pos_r, token_length: '0,
              error_code: err_base, run_end: 1'b0};
    has_c = fin_r && (mode_mid != MODE_IDLE);
    res_c.token_offset = start_mid;
    res_c.token_length = full;
    res_c.run_end      = 1'b0;
    case (mode_mid)
      MODE_INT:  begin
        res_c.token_kind = KIND_INT;
        res_c.error_code = err_base;
      end
      MODE_REAL: begin
        res_c.token_kind = KIND_REAL;
        res_c.error_code = err_base;
      end
      default: begin
        res_c.token_kind = KIND_NONE;
        res_c.error_code = ovf_r ? ERR_TOO_LONG : ERR_UNTERM;
      end
    endcase

    // A punctuation token leaves idle, so at most two of the three appear
    push.count  = advance ? 2'({1'b0, has_a} + {1'b0, has_b} + {1'b0, has_c}) : 2'd0;
    push.first  = has_a ? res_a : (has_b ? res_b : res_c);
    push.second = (has_a && has_b) ? res_b : res_c;
    push.first.run_end  = (push.count == 2'd1);
    push.second.run_end = 1'b1;

    if (fin_r) begin
      mode_nxt  = MODE_IDLE;
      start_nxt = '0;
      pos_nxt   = '0;
      ovf_nxt   = 1'b0;
    end else begin
      mode_nxt  = mode_mid;
      start_nxt = start_mid;
      pos_nxt   = pos_r;
      ovf_nxt   = ovf_r;
      if (!ovf_r) begin
        if (pos_r == POS_LAST) begin
          ovf_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      ovf_r   <= 1'b0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

`ifndef SYNTHESIS
  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    advance && fin_r |=> mode_r == MODE_IDLE && pos_r == '0 && !ovf_r)
    else $error("state not cleared after final byte");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> pos_r == POS_LAST && start_r <= pos_r)
    else $error("offset not saturated under overflow");

  a_pos_steps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !fin_r && !ovf_r && pos_r != POS_LAST |=> pos_r == $past(pos_r) + POS_W'(1))
    else $error("byte offset did not advance by one");
`endif

endmodule

// ===== sv/jbt_result_fifo.sv =====
module jbt_result_fifo
  import jbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  jbt_push_t   push,
  output logic        space_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output jbt_result_t out_res
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  jbt_result_t     mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r, count_nxt;
  logic            pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // Room for the worst case of two results from one byte
  assign space_ok  = (count_r <= (AW+1)'(DEPTH - 2));
  assign count_nxt = count_r + (AW+1)'(push.count) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_r + AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(push.count);
      rd_ptr_r <= rd_ptr_r + AW'(pop);
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 |-> count_r + (AW+1)'(push.count) <= (AW+1)'(DEPTH))
    else $error("result queue overrun");

  a_push_gated: assert property (@(posedge clk) disable iff (!rst_n)
    !space_ok |-> push.count == 2'd0)
    else $error("push while queue lacks room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH))
    else $error("result queue count out of range");
`endif

endmodule

// ===== sv/json_byte_tokenizer.sv =====
// Channel  Dir  Beat
// in_chan  in   data_byte[7:0], final_byte
// out_chan out  token_kind[3:0], token_offset[15:0], token_length[15:0],
//               error_code[1:0], run_end
//
// One byte per clock while the queue has room, through an input register and
// combinational lexing. Each byte yields zero, one or two tokens into a
// four-entry result queue; the output delivers one token per clock while the
// sink is ready, so bytes with two tokens set the sustained rate when tokens
// are dense. rst_n is synchronous; it returns the lexer to idle at offset zero.
// A byte waits in the input register while the queue has fewer than two free.
module json_byte_tokenizer
  import jbt_pkg::*;
#(
  parameter int unsigned MAX_DOC_BYTES = 65536
) (
  input logic        clk,
  input logic        rst_n,
  jbt_in_if.sink     in_chan,
  jbt_out_if.source  out_chan
);

  jbt_push_t   push;
  logic        space_ok;
  jbt_result_t head;

  jbt_lexer_core #(
    .MAX_DOC_BYTES(MAX_DOC_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_data  (in_chan.data_byte),
    .in_final (in_chan.final_byte),
    .space_ok (space_ok),
    .push     (push)
  );

  jbt_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (head)
  );

  assign out_chan.token_kind   = head.token_kind;
  assign out_chan.token_offset = head.token_offset;
  assign out_chan.token_length = head.token_length;
  assign out_chan.error_code   = head.error_code;
  assign out_chan.run_end      = head.run_end;

endmodule

// ===== test/json_byte_tokenizer_tb.sv =====
module json_byte_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jbt_pkg::*;

  localparam int unsigned OFFSET_LIMIT = 65536;
  localparam int          RANDOM_BYTES = 1250;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {LEX_IDLE, LEX_IDENT, LEX_INT, LEX_REAL} lex_mode_e;

  // n < 0: results come from the lexer model; otherwise they are typed in
  typedef struct {
    logic [7:0]  b;
    logic        fin;
    int          n;
    jbt_result_t tok;
  } stim_row_t;

  logic clk;
  logic rst_n;

  jbt_in_if  in_chan ();
  jbt_out_if out_chan ();

  json_byte_tokenizer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // lexer model state
  lex_mode_e   lex_mode;
  int unsigned lex_pos;
  int unsigned tok_start;
  bit          lex_ovf;
  jbt_result_t step_res [2];
  int          step_n;

  jbt_result_t pending_tokens [$];
  stim_row_t   dir_rows [$];
  logic [7:0]  doc_q [$];

  logic [7:0] punct_set [7] = '{CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET,
                                CH_QUOTE, CH_COMMA, CH_COLON};
  logic [7:0] space_set [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  int  errors;
  int  tokens_seen;
  int  bytes_sent;
  int  docs_sent;
  int  rand_bytes;
  bit  steady;
  jbt_result_t got_tok;
  jbt_result_t want_tok;

  always #6 clk = ~clk;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [3:0] punct_kind(logic [7:0] c);
    case (c)
      CH_LBRACE:   return KIND_LBRACE;
      CH_RBRACE:   return KIND_RBRACE;
      CH_LBRACKET: return KIND_LBRACKET;
      CH_RBRACKET: return KIND_RBRACKET;
      CH_QUOTE:    return KIND_QUOTE;
      CH_COMMA:    return KIND_COMMA;
      CH_COLON:    return KIND_COLON;
      default:     return KIND_NONE;
    endcase
  endfunction

  function automatic void lex_reset();
    lex_mode  = LEX_IDLE;
    lex_pos   = 0;
    tok_start = 0;
    lex_ovf   = 1'b0;
  endfunction

  function automatic void emit(logic [3:0] kind, int unsigned off, int unsigned len,
                               logic [1:0] err);
    jbt_result_t r;
    if (step_n >= 2) return;
    if (len > 32'hFFFF) len = 32'hFFFF;
    r.token_kind   = kind;
    r.token_offset = 16'(off);
    r.token_length = 16'(len);
    r.error_code   = lex_ovf ? ERR_TOO_LONG : err;
    r.run_end      = 1'b0;
    step_res[step_n] = r;
    step_n++;
  endfunction

  function automatic void lex_idle(logic [7:0] c);
    logic [3:0] k;
    if (is_space(c)) return;
    k = punct_kind(c);
    if (k != KIND_NONE) begin
      emit(k, lex_pos, 0, ERR_OK);
    end else if (is_digit(c) || c == CH_MINUS) begin
      lex_mode  = LEX_INT;
      tok_start = lex_pos;
    end else begin
      lex_mode  = LEX_IDENT;
      tok_start = lex_pos;
    end
  endfunction

  // Advance the lexer model by one byte; results land in step_res[0:step_n-1]
  function automatic void lex_predict(logic [7:0] c, logic fin);
    int unsigned span;
    int unsigned full;
    span   = (tok_start > lex_pos) ? 0 : lex_pos - tok_start;
    step_n = 0;
    case (lex_mode)
      LEX_IDENT: begin
        if (c == CH_COMMA || c == CH_QUOTE) begin
          emit(KIND_IDENT, tok_start, span, ERR_OK);
          lex_mode = LEX_IDLE;
          lex_idle(c);
        end
      end
      LEX_INT: begin
        if (c == CH_DOT) begin
          lex_mode = LEX_REAL;
        end else if (!is_digit(c)) begin
          emit(KIND_INT, tok_start, span, ERR_OK);
          lex_mode = LEX_IDLE;
          lex_idle(c);
        end
      end
      LEX_REAL: begin
        if (!is_digit(c)) begin
          emit(KIND_REAL, tok_start, span, ERR_OK);
          lex_mode = LEX_IDLE;
          lex_idle(c);
        end
      end
      default: begin
        lex_mode = LEX_IDLE;
        lex_idle(c);
      end
    endcase
    if (fin) begin
      // flush the open token with the last byte included
      full = (tok_start > lex_pos) ? 1 : lex_pos - tok_start + 1;
      case (lex_mode)
        LEX_INT:   emit(KIND_INT, tok_start, full, ERR_OK);
        LEX_REAL:  emit(KIND_REAL, tok_start, full, ERR_OK);
        LEX_IDENT: emit(KIND_NONE, tok_start, full, ERR_UNTERM);
        default: ;
      endcase
      lex_reset();
    end else if (!lex_ovf) begin
      if (lex_pos + 1 >= OFFSET_LIMIT) lex_ovf = 1'b1;
      else lex_pos++;
    end
    if (step_n > 0) step_res[step_n-1].run_end = 1'b1;
  endfunction

  function automatic void push_predicted();
    for (int i = 0; i < step_n; i++) pending_tokens.push_back(step_res[i]);
  endfunction

  function automatic void add_row(logic [7:0] b, logic fin, int n, logic [3:0] k,
                                  int unsigned off, int unsigned len, logic [1:0] err);
    stim_row_t row;
    row.b   = b;
    row.fin = fin;
    row.n   = n;
    row.tok.token_kind   = k;
    row.tok.token_offset = 16'(off);
    row.tok.token_length = 16'(len);
    row.tok.error_code   = err;
    row.tok.run_end      = 1'b1;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [7:0] ident_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_COMMA || c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] digit_byte();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // Append a run of mostly well-formed tokens to doc_q
  function automatic void append_tokens(int ntok);
    int len;
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(0, 11))
        0, 1: doc_q.push_back(punct_set[$urandom_range(0, 6)]);
        2: doc_q.push_back(space_set[$urandom_range(0, 5)]);
        3, 4: begin
          if ($urandom_range(0, 1)) doc_q.push_back(CH_MINUS);
          len = $urandom_range(1, 5);
          for (int j = 0; j < len; j++) doc_q.push_back(digit_byte());
        end
        5: begin
          if ($urandom_range(0, 1)) doc_q.push_back(CH_MINUS);
          len = $urandom_range(1, 3);
          for (int j = 0; j < len; j++) doc_q.push_back(digit_byte());
          doc_q.push_back(CH_DOT);
          len = $urandom_range(0, 3);
          for (int j = 0; j < len; j++) doc_q.push_back(digit_byte());
        end
        6, 7: begin
          doc_q.push_back(8'("a" + $urandom_range(0, 25)));
          len = $urandom_range(0, 5);
          for (int j = 0; j < len; j++) doc_q.push_back(ident_byte());
          doc_q.push_back($urandom_range(0, 1) ? CH_COMMA : CH_QUOTE);
        end
        8: begin
          doc_q.push_back(CH_QUOTE);
          doc_q.push_back(8'("A" + $urandom_range(0, 25)));
          len = $urandom_range(0, 4);
          for (int j = 0; j < len; j++) doc_q.push_back(ident_byte());
          doc_q.push_back(CH_QUOTE);
        end
        9: doc_q.push_back(8'($urandom_range(0, 255)));
        10: begin
          // broken numbers: lone minus, lone dot, repeated dots
          case ($urandom_range(0, 2))
            0: doc_q.push_back(CH_MINUS);
            1: doc_q.push_back(CH_DOT);
            default: begin
              doc_q.push_back(digit_byte());
              doc_q.push_back(CH_DOT);
              doc_q.push_back(digit_byte());
              doc_q.push_back(CH_DOT);
              doc_q.push_back(digit_byte());
            end
          endcase
        end
        default: doc_q.push_back(CH_COLON);
      endcase
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic fin);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.data_byte  <= b;
    in_chan.final_byte <= fin;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc_q.size(); i++) begin
      send_byte(doc_q[i], i == doc_q.size() - 1);
      lex_predict(doc_q[i], i == doc_q.size() - 1);
      push_predicted();
    end
    docs_sent++;
    doc_q.delete();
  endtask

  task automatic drain();
    while (pending_tokens.size() > 0) @(posedge clk);
  endtask

  task automatic report(string what, jbt_result_t want, jbt_result_t got);
    errors++;
    if (errors <= 10) begin
      $write("%0t %s: expected kind %0d off %0d len %0d err %0d end %0d,",
             $realtime, what, want.token_kind, want.token_offset, want.token_length,
             want.error_code, want.run_end);
      $display(" got kind %0d off %0d len %0d err %0d end %0d",
               got.token_kind, got.token_offset, got.token_length, got.error_code,
               got.run_end);
    end
  endtask

  // token sink: random backpressure except during the steady stretch
  always @(posedge clk) begin
    out_chan.ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      tokens_seen++;
      got_tok.token_kind   = out_chan.token_kind;
      got_tok.token_offset = out_chan.token_offset;
      got_tok.token_length = out_chan.token_length;
      got_tok.error_code   = out_chan.error_code;
      got_tok.run_end      = out_chan.run_end;
      if (pending_tokens.size() == 0) begin
        report("unexpected token", '0, got_tok);
      end else begin
        want_tok = pending_tokens.pop_front();
        if (got_tok.token_kind !== want_tok.token_kind
            || got_tok.token_offset !== want_tok.token_offset
            || got_tok.token_length !== want_tok.token_length
            || got_tok.error_code !== want_tok.error_code
            || got_tok.run_end !== want_tok.run_end)
          report("token mismatch", want_tok, got_tok);
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.data_byte  = '0;
    in_chan.final_byte = 1'b0;
    errors      = 0;
    tokens_seen = 0;
    bytes_sent  = 0;
    docs_sent   = 0;
    rand_bytes  = 0;
    steady      = 1'b0;
    lex_reset();

    add_row(CH_LBRACE,   0,  1, KIND_LBRACE, 0, 0, ERR_OK);
    add_row(8'h20,       0,  0, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_MINUS,    0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row("1",         0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_DOT,      0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row("5",         0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_COMMA,    0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_MINUS,    0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_COLON,    0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_LBRACKET, 0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row("9",         0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_DOT,      0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_DOT,      0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(8'hFF,       0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(8'h00,       0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_QUOTE,    0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_RBRACKET, 0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_RBRACE,   0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(8'h0B,       0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row("7",         0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row("8",         1, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row("z",         0,  0, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_RBRACE,   1,  1, KIND_NONE,   0, 2, ERR_UNTERM);
    add_row("5",         1,  1, KIND_INT,    0, 1, ERR_OK);
    add_row(8'h0D,       1,  0, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_COMMA,    1,  1, KIND_COMMA,  0, 0, ERR_OK);
    add_row("3",         0, -1, KIND_NONE,   0, 0, ERR_OK);
    add_row(CH_DOT,      1, -1, KIND_NONE,   0, 0, ERR_OK);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].fin);
      lex_predict(dir_rows[i].b, dir_rows[i].fin);
      if (dir_rows[i].n < 0) push_predicted();
      else if (dir_rows[i].n > 0) pending_tokens.push_back(dir_rows[i].tok);
    end

    // hold the sender until the lexer has emptied
    in_chan.valid <= 1'b0;
    drain();

    while (rand_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 99) < 85) append_tokens($urandom_range(1, 12));
      else repeat ($urandom_range(1, 10)) doc_q.push_back(8'($urandom_range(0, 255)));
      rand_bytes += doc_q.size();
      steady = rand_bytes >= 500 && rand_bytes < 750;
      send_doc();
    end
    steady = 1'b0;

    in_chan.valid <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    errors += pending_tokens.size();

    $display("Lexed %0d documents, %0d bytes; checked %0d tokens.", docs_sent, bytes_sent,
             tokens_seen);
    $display("Included punctuation, numbers, identifiers, broken numbers and flushes.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
